// ===== src/sgrs_pkg.sv =====
// Package for the scatter-gather range slicer: item types, codes and limits.
`default_nettype none

package sgrs_pkg;

  // Hard cap on destination entries, applied on top of the register value
  localparam int ENTRY_LIMIT = 256;

  // Widths fixed by the item layout
  localparam int ADDR_W = 64;
  localparam int LEN_W  = 32;
  localparam int PGO_W  = 16;
  localparam int CNT_W  = 9;
  localparam int ST_W   = 2;

  // Reset value of max_out_entries
  localparam logic [CNT_W-1:0] MAX_OUT_RESET = CNT_W'(64);

  // Action codes
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_FRAG  = 1'b1;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_TOO_MANY  = 2'd1;
  localparam logic [ST_W-1:0] ST_EXHAUSTED = 2'd2;

  // Extraction phase, one-hot
  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_SKIP = 4'b0010,
    PH_EMIT = 4'b0100,
    PH_FIN  = 4'b1000
  } phase_t;

  typedef struct packed {
    logic              action;
    logic [LEN_W-1:0]  start_offset;
    logic [LEN_W-1:0]  total_length;
    logic [ADDR_W-1:0] frag_base;
    logic [PGO_W-1:0]  frag_page_offset;
    logic [LEN_W-1:0]  frag_bytes;
    logic              last_fragment;
  } sgrs_in_t;

  typedef struct packed {
    logic [ADDR_W-1:0] out_base;
    logic [LEN_W-1:0]  out_len;
    logic [CNT_W-1:0]  entry_index;
    logic              done_res;
    logic [ST_W-1:0]   status;
  } sgrs_out_t;

endpackage

`default_nettype wire

// ===== src/sgrs_slice.sv =====
// Slicing stage: extraction state, per-fragment decision and result register.
`default_nettype none

module sgrs_slice import sgrs_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  output logic                  item_ready,
  input  wire sgrs_in_t         item,
  input  wire logic [CNT_W-1:0] max_out_entries,
  output logic                  res_valid,
  input  wire logic             res_ready,
  output sgrs_out_t             res
);

  phase_t           phase, phase_next;
  logic [LEN_W-1:0] offset_left, offset_left_next;
  logic [LEN_W-1:0] length_left, length_left_next;
  logic [CNT_W-1:0] entries_emitted, entries_emitted_next;

  logic             adv;
  logic             emit;
  sgrs_out_t        res_next;
  logic [CNT_W-1:0] limit;
  logic [LEN_W-1:0] avail;
  logic             takes_rest;
  logic [LEN_W-1:0] n;
  logic [CNT_W-1:0] idx;

  // Item moves through whenever the result register can take its outcome
  assign item_ready = !res_valid || res_ready;
  assign adv        = item_valid && item_ready;

  // Limit in force: register value capped by the hard limit
  always_comb begin
    if (32'(max_out_entries) > ENTRY_LIMIT) begin
      limit = CNT_W'(ENTRY_LIMIT);
    end else begin
      limit = max_out_entries;
    end
  end

  // Entry arithmetic for a fragment that is emitted
  assign avail      = item.frag_bytes - offset_left;
  assign takes_rest = avail >= length_left;
  assign n          = takes_rest ? length_left : avail;
  assign idx        = entries_emitted + CNT_W'(1);

  // Next state and result for one item
  always_comb begin
    phase_next           = phase;
    offset_left_next     = offset_left;
    length_left_next     = length_left;
    entries_emitted_next = entries_emitted;
    emit                 = 1'b0;
    res_next             = '0;

    if (item.action == ACT_START) begin
      offset_left_next     = item.start_offset;
      length_left_next     = item.total_length;
      entries_emitted_next = '0;
      if (item.total_length == '0) begin
        phase_next        = PH_FIN;
        emit              = 1'b1;
        res_next.done_res = 1'b1;
        res_next.status   = ST_OK;
      end else begin
        phase_next = PH_SKIP;
      end
    end else if (phase == PH_IDLE || phase == PH_FIN) begin
      // fragments outside an extraction are dropped
    end else if (phase == PH_SKIP && offset_left >= item.frag_bytes) begin
      offset_left_next = offset_left - item.frag_bytes;
      if (item.last_fragment) begin
        phase_next      = PH_FIN;
        emit            = 1'b1;
        res_next.status = ST_EXHAUSTED;
      end
    end else if (entries_emitted >= limit) begin
      phase_next      = PH_FIN;
      emit            = 1'b1;
      res_next.status = ST_TOO_MANY;
    end else begin
      emit                 = 1'b1;
      res_next.out_base    = item.frag_base + ADDR_W'(item.frag_page_offset)
                             + ADDR_W'(offset_left);
      res_next.out_len     = n;
      res_next.entry_index = idx;
      entries_emitted_next = idx;
      length_left_next     = length_left - n;
      offset_left_next     = '0;
      if (takes_rest) begin
        phase_next        = PH_FIN;
        res_next.done_res = 1'b1;
        res_next.status   = ST_OK;
      end else if (item.last_fragment) begin
        phase_next      = PH_FIN;
        res_next.status = ST_EXHAUSTED;
      end else begin
        phase_next      = PH_EMIT;
        res_next.status = ST_OK;
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      offset_left     <= '0;
      length_left     <= '0;
      entries_emitted <= '0;
    end else if (adv) begin
      phase           <= phase_next;
      offset_left     <= offset_left_next;
      length_left     <= length_left_next;
      entries_emitted <= entries_emitted_next;
    end
  end

  // Result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= emit;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (adv && emit) begin
      res <= res_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/scatter_gather_range_slicer_top.sv =====
// Top level of the scatter-gather range slicer: input register, config register, slice stage.
// A source item passes the input register, then the slice stage's result register, to dst_valid.
// Throughput: one source item per cycle while dst_ready stays high; a result left waiting
// holds the slice stage, an empty input register takes one more item, then src_ready drops.
// Reset (rst, synchronous): no extraction in progress, both registers empty,
// max_out_entries back to 64.
`default_nettype none

module scatter_gather_range_slicer_top import sgrs_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             src_valid,
  output logic                  src_ready,
  input  wire sgrs_in_t         src_item,
  output logic                  dst_valid,
  input  wire logic             dst_ready,
  output sgrs_out_t             dst_item,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [CNT_W-1:0] cfg_data
);

  logic             hold_valid;
  sgrs_in_t         hold_item;
  logic             slice_ready;
  logic [CNT_W-1:0] max_out_entries;

  // Config register, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_out_entries <= MAX_OUT_RESET;
    end else if (cfg_valid) begin
      max_out_entries <= cfg_data;
    end
  end

  // Input register
  assign src_ready = !hold_valid || slice_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (src_ready) begin
      hold_valid <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (src_valid && src_ready) begin
      hold_item <= src_item;
    end
  end

  // Slice stage with result register
  sgrs_slice u_slice (
    .clk             (clk),
    .rst             (rst),
    .item_valid      (hold_valid),
    .item_ready      (slice_ready),
    .item            (hold_item),
    .max_out_entries (max_out_entries),
    .res_valid       (dst_valid),
    .res_ready       (dst_ready),
    .res             (dst_item)
  );

endmodule

`default_nettype wire

// ===== sim/scatter_gather_range_slicer_top_tb.sv =====
// Self-checking testbench for the scatter-gather range slicer top level.
`timescale 1ns / 100ps

module scatter_gather_range_slicer_top_tb;
  import sgrs_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int NUM_SETTINGS = 9;
  localparam int ITEMS_PER_SETTING = 130;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic src_valid = 1'b0;
  logic src_ready;
  sgrs_in_t src_item = '0;
  logic dst_valid;
  logic dst_ready = 1'b0;
  sgrs_out_t dst_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CNT_W-1:0] cfg_data = '0;

  scatter_gather_range_slicer_top uut (
    .clk(clk),
    .rst(rst),
    .src_valid(src_valid),
    .src_ready(src_ready),
    .src_item(src_item),
    .dst_valid(dst_valid),
    .dst_ready(dst_ready),
    .dst_item(dst_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // Source items waiting to be driven, destination entries still owed by the block
  sgrs_in_t src_backlog[$];
  sgrs_out_t dest_due[$];

  // Shadow of the slicer state and its limit register
  phase_t slice_phase = PH_IDLE;
  logic [LEN_W-1:0] offset_left = '0;
  logic [LEN_W-1:0] length_left = '0;
  logic [CNT_W-1:0] entries_out = '0;
  logic [CNT_W-1:0] max_entries = MAX_OUT_RESET;

  int src_idle_pct = 0;
  int dst_idle_pct = 0;
  int errors = 0;
  int cycles = 0;
  int n_src = 0;
  int n_res = 0;
  int n_done = 0;
  int n_too_many = 0;
  int n_exhausted = 0;
  int n_counted = 0;

  // Work out what one accepted source item makes the block emit
  task automatic slice_item(input sgrs_in_t it);
    sgrs_out_t r;
    logic [LEN_W-1:0] avail;
    logic [LEN_W-1:0] take;
    int lim;
    r = '0;
    if (it.action == ACT_START) begin
      // a start always restarts
      offset_left = it.start_offset;
      length_left = it.total_length;
      entries_out = '0;
      if (length_left == '0) begin
        slice_phase = PH_FIN;
        r.done_res = 1'b1;
        r.status = ST_OK;
        dest_due.push_back(r);
      end else begin
        slice_phase = PH_SKIP;
      end
    end else if (slice_phase == PH_SKIP || slice_phase == PH_EMIT) begin
      if (slice_phase == PH_SKIP && offset_left >= it.frag_bytes) begin
        // whole fragment lies before the range
        offset_left = offset_left - it.frag_bytes;
        if (it.last_fragment) begin
          slice_phase = PH_FIN;
          r.status = ST_EXHAUSTED;
          dest_due.push_back(r);
        end
      end else begin
        lim = (int'(max_entries) > ENTRY_LIMIT) ? ENTRY_LIMIT : int'(max_entries);
        if (int'(entries_out) >= lim) begin
          slice_phase = PH_FIN;
          r.status = ST_TOO_MANY;
        end else begin
          avail = it.frag_bytes - offset_left;
          take = (avail < length_left) ? avail : length_left;
          r.out_base = it.frag_base + ADDR_W'(it.frag_page_offset) + ADDR_W'(offset_left);
          entries_out = entries_out + 1'b1;
          length_left = length_left - take;
          offset_left = '0;
          r.out_len = take;
          r.entry_index = entries_out;
          if (length_left == '0) begin
            slice_phase = PH_FIN;
            r.done_res = 1'b1;
            r.status = ST_OK;
          end else if (it.last_fragment) begin
            slice_phase = PH_FIN;
            r.status = ST_EXHAUSTED;
          end else begin
            slice_phase = PH_EMIT;
            r.status = ST_OK;
          end
        end
        dest_due.push_back(r);
      end
    end
  endtask

  function automatic logic [ADDR_W-1:0] rand_base();
    // near the top of the space now and then, so the address sum wraps
    if ($urandom_range(3) == 0)
      return ~ADDR_W'($urandom_range(4095));
    return {$urandom, $urandom};
  endfunction

  function automatic logic [PGO_W-1:0] rand_pgo();
    if ($urandom_range(3) == 0)
      return '0;
    return PGO_W'($urandom);
  endfunction

  function automatic sgrs_in_t mk_start(input logic [LEN_W-1:0] off,
                                        input logic [LEN_W-1:0] len);
    sgrs_in_t it;
    it.action = ACT_START;
    it.start_offset = off;
    it.total_length = len;
    it.frag_base = rand_base();
    it.frag_page_offset = PGO_W'($urandom);
    it.frag_bytes = $urandom;
    it.last_fragment = 1'($urandom_range(1));
    return it;
  endfunction

  function automatic sgrs_in_t mk_frag(input logic [ADDR_W-1:0] base,
                                       input logic [PGO_W-1:0] pgo,
                                       input logic [LEN_W-1:0] len,
                                       input logic last);
    sgrs_in_t it;
    it.action = ACT_FRAG;
    it.start_offset = $urandom;
    it.total_length = $urandom;
    it.frag_base = base;
    it.frag_page_offset = pgo;
    it.frag_bytes = len;
    it.last_fragment = last;
    return it;
  endfunction

  task automatic queue_item(input sgrs_in_t it, input bit counts);
    src_backlog.push_back(it);
    if (counts)
      n_counted++;
  endtask

  task automatic queue_frag(input logic [LEN_W-1:0] len, input logic last);
    queue_item(mk_frag(rand_base(), rand_pgo(), len, last), 1'b1);
  endtask

  // Edge cases first: empty range, skips, wrap, zero-length entry, early end, restart
  task automatic queue_directed();
    queue_item(mk_frag(rand_base(), rand_pgo(), 32'd100, 1'b0), 1'b0);
    queue_item(mk_start(32'd0, 32'd0), 1'b1);
    queue_item(mk_frag(rand_base(), rand_pgo(), 32'd100, 1'b1), 1'b0);
    queue_item(mk_start(32'd10, 32'd100), 1'b1);
    queue_frag(32'd4, 1'b0);
    queue_frag(32'd6, 1'b0);
    queue_item(mk_frag('1, '1, 32'd50, 1'b0), 1'b1);
    queue_frag(32'd0, 1'b0);
    queue_frag(32'd80, 1'b1);
    queue_item(mk_start(32'd100, 32'd5), 1'b1);
    queue_frag(32'd10, 1'b1);
    queue_item(mk_start(32'd0, 32'd1000), 1'b1);
    queue_frag(32'd20, 1'b0);
    queue_frag(32'd30, 1'b1);
    queue_item(mk_start('1, '1), 1'b1);
    queue_item(mk_frag('0, '0, '1, 1'b0), 1'b1);
    queue_item(mk_frag('1, '0, '1, 1'b0), 1'b1);
    queue_item(mk_start(32'd0, 32'd100), 1'b1);
    queue_frag(32'd30, 1'b0);
    queue_item(mk_start(32'd0, 32'd1), 1'b1);
    queue_frag(32'd7, 1'b1);
  endtask

  // More fragments than any limit allows, so the entry cap trips
  task automatic queue_overflow_run();
    queue_item(mk_start($urandom_range(3), 32'd100000), 1'b1);
    for (int i = 0; i < 262; i++)
      queue_frag($urandom_range(1, 4), i == 261);
  endtask

  task automatic queue_random_sequence();
    int kind;
    int nfrag;
    sgrs_in_t it;
    kind = $urandom_range(99);
    if (kind < 70) begin
      // well-formed list with small sizes
      queue_item(mk_start(($urandom_range(3) == 0) ? 0 : $urandom_range(2000),
                          $urandom_range(1, 3000)), 1'b1);
      nfrag = $urandom_range(1, 10);
      for (int i = 0; i < nfrag; i++)
        queue_frag(($urandom_range(9) == 0) ? 0 : $urandom_range(1, 800),
                   (i == nfrag - 1) && ($urandom_range(9) != 0));
    end else if (kind < 80) begin
      // full-width offsets and lengths
      queue_item(mk_start($urandom, $urandom), 1'b1);
      nfrag = $urandom_range(1, 4);
      for (int i = 0; i < nfrag; i++)
        queue_frag($urandom, 1'($urandom_range(1)));
    end else if (kind < 90) begin
      // noise: any action, any content
      nfrag = $urandom_range(1, 3);
      for (int i = 0; i < nfrag; i++) begin
        it = mk_frag(rand_base(), rand_pgo(), $urandom, 1'($urandom_range(1)));
        it.action = 1'($urandom_range(1));
        queue_item(it, 1'b0);
      end
    end else begin
      // source runs out before the range is covered
      queue_item(mk_start($urandom_range(500), 32'd5000), 1'b1);
      nfrag = $urandom_range(1, 3);
      for (int i = 0; i < nfrag; i++)
        queue_frag($urandom_range(0, 400), i == nfrag - 1);
    end
  endtask

  // Wait until the driver is empty and every owed entry has arrived
  task automatic wait_drained();
    @(posedge clk);
    while (src_backlog.size() != 0 || src_valid || dest_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Source driver: one transfer per handshake, random gaps per idle setting
  always @(posedge clk) begin
    if (rst) begin
      src_valid <= 1'b0;
    end else begin
      if (src_valid && src_ready) begin
        slice_item(src_item);
        n_src++;
      end
      if (!src_valid || src_ready) begin
        if (src_backlog.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          src_valid <= 1'b1;
          src_item <= src_backlog.pop_front();
        end else begin
          src_valid <= 1'b0;
        end
      end
    end
  end

  // Result side: random back-pressure, field-by-field check against the oldest owed entry
  always @(posedge clk) begin : dst_side
    sgrs_out_t want;
    if (rst) begin
      dst_ready <= 1'b0;
    end else begin
      dst_ready <= ($urandom_range(99) >= dst_idle_pct);
      if (dst_valid && dst_ready) begin
        n_res++;
        if (dst_item.done_res) n_done++;
        if (dst_item.status == ST_TOO_MANY) n_too_many++;
        if (dst_item.status == ST_EXHAUSTED) n_exhausted++;
        if (dest_due.size() == 0) begin
          $display("%0t: unexpected result transfer, expected none, got %h", $time, dst_item);
          errors++;
        end else begin
          want = dest_due.pop_front();
          if (dst_item.out_base !== want.out_base) begin
            $display("%0t: out_base expected %h got %h", $time, want.out_base,
                     dst_item.out_base);
            errors++;
          end
          if (dst_item.out_len !== want.out_len) begin
            $display("%0t: out_len expected %h got %h", $time, want.out_len, dst_item.out_len);
            errors++;
          end
          if (dst_item.entry_index !== want.entry_index) begin
            $display("%0t: entry_index expected %0d got %0d", $time, want.entry_index,
                     dst_item.entry_index);
            errors++;
          end
          if (dst_item.done_res !== want.done_res) begin
            $display("%0t: done_res expected %b got %b", $time, want.done_res,
                     dst_item.done_res);
            errors++;
          end
          if (dst_item.status !== want.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status, dst_item.status);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still owed", $time, dest_due.size());
      $display("scatter_gather_range_slicer_top_tb: errors");
      $finish;
    end
  end

  // Sequencer: limit settings mix extreme and ordinary values, idle mix shifts over the run
  initial begin
    int unsigned limit_plan[NUM_SETTINGS];
    int mode;
    limit_plan = '{64, 1, 256, 0, 511, 3, 2, 17, 64};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    for (int p = 0; p < NUM_SETTINGS; p++) begin
      mode = p * 3 / NUM_SETTINGS;
      src_idle_pct = (mode == 0) ? 20 : (mode == 1) ? 48 : 0;
      dst_idle_pct = (mode == 0) ? 48 : (mode == 1) ? 20 : 0;
      if (p != 0) begin
        // register write while the block is idle
        cfg_valid <= 1'b1;
        cfg_data <= CNT_W'(limit_plan[p]);
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        max_entries = CNT_W'(limit_plan[p]);
        cfg_valid <= 1'b0;
      end
      n_counted = 0;
      if (p == 0)
        queue_directed();
      if (limit_plan[p] >= ENTRY_LIMIT)
        queue_overflow_run();
      while (n_counted < ITEMS_PER_SETTING)
        queue_random_sequence();
      wait_drained();
    end
    $display("Run covered %0d source transfers over %0d entry-limit settings;",
             n_src, NUM_SETTINGS);
    $display("  %0d results: %0d completed lists, %0d over the entry cap, %0d source ran out.",
             n_res, n_done, n_too_many, n_exhausted);
    if (errors == 0) begin
      $display("scatter_gather_range_slicer_top_tb: clean");
    end else begin
      $display("scatter_gather_range_slicer_top_tb: errors");
    end
    $finish;
  end

endmodule
